// ----- src/ats_pkg.sv -----
// Package for the affine transform save stack.
// Holds widths, command codes and the item and matrix types shared by all modules.
// No dependencies.
package ats_pkg;

    localparam int COEF_W      = 32;
    localparam int N_COEF      = 6;
    localparam int FRAC_BITS   = 16;
    localparam int STACK_DEPTH = 32;
    localparam int CMD_W       = 3;
    localparam int CNT_W       = 3;
    localparam int LEVEL_OUT_W = 6;
    localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PROD_W      = 2 * COEF_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam int S_TDATA_W   = ((N_COEF * COEF_W + CNT_W + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((N_COEF * COEF_W + 1 + LEVEL_OUT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SAVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONCAT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef f;
        t_coef e;
        t_coef d;
        t_coef c;
        t_coef b;
        t_coef a;
    } t_mat;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        t_mat             m;
        logic             lost;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam t_coef COEF_ONE = t_coef'(64'd1 << FRAC_BITS);

endpackage

// ----- src/ats_front.sv -----
// Front end: unpacks incoming transfers and classifies them into queue items.
// Depends on ats_pkg.
module ats_front import ats_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [S_TDATA_W-1:0] i_data,
    input  logic [CMD_W-1:0]     i_user,
    input  t_q_status            i_q_status,
    output logic                 o_push,
    output t_item                o_item
);

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_eff;
    logic             is_concat;
    t_mat             raw;

    assign raw     = i_data[N_COEF*COEF_W-1:0];
    assign cnt     = i_data[N_COEF*COEF_W +: CNT_W];
    assign cnt_eff = (cnt > CNT_W'(N_COEF)) ? CNT_W'(N_COEF) : cnt;
    assign is_concat = (i_user == CMD_CONCAT);

    assign o_ready = !i_q_status.full && i_rst_n;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_item      = '0;
        o_item.lost = i_data[N_COEF*COEF_W + CNT_W];
        o_item.m    = raw;
        case (i_user)
            CMD_BEGIN, CMD_SAVE, CMD_RESTORE, CMD_CONCAT: o_item.op = i_user;
            default:                                      o_item.op = CMD_QUERY;
        endcase
        // leading operands that are not present count as zero
        if (is_concat) begin
            if (cnt_eff < CNT_W'(6)) o_item.m.a = '0;
            if (cnt_eff < CNT_W'(5)) o_item.m.b = '0;
            if (cnt_eff < CNT_W'(4)) o_item.m.c = '0;
            if (cnt_eff < CNT_W'(3)) o_item.m.d = '0;
            if (cnt_eff < CNT_W'(2)) o_item.m.e = '0;
            if (cnt_eff < CNT_W'(1)) o_item.m.f = '0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_status.full)
        else $error("push into full queue");

endmodule

// ----- src/ats_queue.sv -----
// Short queue between front and back end, register based.
// Depends on ats_pkg.
module ats_queue import ats_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overrun");

endmodule

// ----- src/ats_back.sv -----
// Back end: executes queued items on the current matrix and the save stack,
// and holds the result register. Depends on ats_pkg.
module ats_back import ats_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_item                i_item,
    input  t_q_status            i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [M_TDATA_W-1:0] o_data
);

    localparam logic ST_EXEC = 1'b0;
    localparam logic ST_FIN  = 1'b1;
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    t_mat                     r_cur, n_cur;
    logic                     r_lost, n_lost;
    logic [LVL_W-1:0]         r_level, n_level;
    logic                     r_state, n_state;
    logic                     r_fin_restore, n_fin_restore;
    logic signed [PROD_W-1:0] r_prod [12];
    t_mat                     r_stack [STACK_DEPTH];
    t_mat                     r_rd_data;
    logic                     r_out_valid;
    t_mat                     r_out_mat;
    logic                     r_out_lost;
    logic [LEVEL_OUT_W-1:0]   r_out_level;
    logic [LVL_W+LEVEL_OUT_W-1:0] level_ext;

    logic              out_free;
    logic              take;
    logic              fin;
    logic              load_out;
    logic              prod_en;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [LVL_W-1:0]  level_dec;
    t_mat              cat;

    function automatic t_coef dot_round(input logic signed [PROD_W-1:0] p,
                                        input logic signed [PROD_W-1:0] q,
                                        input t_coef t);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] sh;
        logic signed [SUM_W:0]   tot;
        logic signed [SUM_W:0]   lim_hi;
        logic signed [SUM_W:0]   lim_lo;
        s      = $signed({p[PROD_W-1], p}) + $signed({q[PROD_W-1], q}) + RND_HALF;
        sh     = s >>> FRAC_BITS;
        tot    = $signed({sh[SUM_W-1], sh})
               + $signed({{(SUM_W+1-COEF_W){t[COEF_W-1]}}, t});
        lim_hi = {{(SUM_W+1-COEF_W){1'b0}}, 1'b0, {(COEF_W-1){1'b1}}};
        lim_lo = {{(SUM_W+1-COEF_W){1'b1}}, 1'b1, {(COEF_W-1){1'b0}}};
        if (tot > lim_hi) begin
            dot_round = {1'b0, {(COEF_W-1){1'b1}}};
        end else if (tot < lim_lo) begin
            dot_round = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            dot_round = tot[COEF_W-1:0];
        end
    endfunction

    assign out_free  = !r_out_valid || i_ready;
    assign take      = (r_state == ST_EXEC) && !i_q_status.empty && out_free;
    assign fin       = (r_state == ST_FIN) && out_free;
    assign o_pop     = take;
    assign level_dec = r_level - 1'b1;
    assign mem_waddr = r_level[ADDR_W-1:0];
    assign mem_raddr = level_dec[ADDR_W-1:0];

    assign cat.a = dot_round(r_prod[0],  r_prod[1],  '0);
    assign cat.b = dot_round(r_prod[2],  r_prod[3],  '0);
    assign cat.c = dot_round(r_prod[4],  r_prod[5],  '0);
    assign cat.d = dot_round(r_prod[6],  r_prod[7],  '0);
    assign cat.e = dot_round(r_prod[8],  r_prod[9],  r_cur.e);
    assign cat.f = dot_round(r_prod[10], r_prod[11], r_cur.f);

    always_comb begin
        n_cur         = r_cur;
        n_lost        = r_lost;
        n_level       = r_level;
        n_state       = r_state;
        n_fin_restore = r_fin_restore;
        load_out      = 1'b0;
        prod_en       = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        if (take) begin
            unique case (i_item.op)
                CMD_BEGIN: begin
                    n_cur    = i_item.m;
                    n_lost   = i_item.lost;
                    n_level  = '0;
                    load_out = 1'b1;
                end
                CMD_SAVE: begin
                    if (!r_lost) begin
                        if (r_level == LVL_W'(STACK_DEPTH)) begin
                            n_lost = 1'b1;
                        end else begin
                            mem_we  = 1'b1;
                            n_level = r_level + 1'b1;
                        end
                    end
                    load_out = 1'b1;
                end
                CMD_RESTORE: begin
                    if (!r_lost && r_level != '0) begin
                        mem_re        = 1'b1;
                        n_level       = level_dec;
                        n_state       = ST_FIN;
                        n_fin_restore = 1'b1;
                    end else begin
                        load_out = 1'b1;
                    end
                end
                CMD_CONCAT: begin
                    prod_en       = 1'b1;
                    n_state       = ST_FIN;
                    n_fin_restore = 1'b0;
                end
                default: begin
                    load_out = 1'b1;
                end
            endcase
        end else if (fin) begin
            n_cur    = r_fin_restore ? r_rd_data : cat;
            n_state  = ST_EXEC;
            load_out = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= '{f: '0, e: '0, d: COEF_ONE, c: '0, b: '0, a: COEF_ONE};
            r_lost        <= 1'b0;
            r_level       <= '0;
            r_state       <= ST_EXEC;
            r_fin_restore <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cur         <= n_cur;
            r_lost        <= n_lost;
            r_level       <= n_level;
            r_state       <= n_state;
            r_fin_restore <= n_fin_restore;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign level_ext = {{LEVEL_OUT_W{1'b0}}, n_level};

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mat   <= n_cur;
            r_out_lost  <= n_lost;
            r_out_level <= level_ext[LEVEL_OUT_W-1:0];
        end
    end

    // operand times current matrix, one register stage before the sums
    always_ff @(posedge i_clk) begin
        if (prod_en) begin
            r_prod[0]  <= i_item.m.a * r_cur.a;
            r_prod[1]  <= i_item.m.b * r_cur.c;
            r_prod[2]  <= i_item.m.a * r_cur.b;
            r_prod[3]  <= i_item.m.b * r_cur.d;
            r_prod[4]  <= i_item.m.c * r_cur.a;
            r_prod[5]  <= i_item.m.d * r_cur.c;
            r_prod[6]  <= i_item.m.c * r_cur.b;
            r_prod[7]  <= i_item.m.d * r_cur.d;
            r_prod[8]  <= i_item.m.e * r_cur.a;
            r_prod[9]  <= i_item.m.f * r_cur.c;
            r_prod[10] <= i_item.m.e * r_cur.b;
            r_prod[11] <= i_item.m.f * r_cur.d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_waddr] <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_stack[mem_raddr];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {{(M_TDATA_W - N_COEF*COEF_W - 1 - LEVEL_OUT_W){1'b0}},
                      r_out_level, r_out_lost, r_out_mat};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> !o_pop)
        else $error("item taken while previous one unfinished");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("stack written and read in one cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_out_valid && r_state == ST_EXEC))
        else $error("finishing item gave no result");

endmodule

// ----- src/affine_transform_save_stack.sv -----
// A simple command is queued, then taken and its result registered; restore and concat
// add a registered stack read or registered products ahead of round and saturate, and
// hold the back end until done. One transfer per cycle in while the queue has room.
// A 4-entry queue decouples input from execution; the result register decouples output.
// Reset (synchronous, i_rst_n low): identity matrix, level 0, lost clear, queue empty.
// Stack contents are not cleared; no clearing pass.
module affine_transform_save_stack import ats_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // coef_a..coef_f [191:0], operand_count [194:192], lost_in [195], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // command [2:0]
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_a..out_f [191:0], lost_flag [192], stack_level [198:193], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_q_status q_status;
    logic      push;
    logic      pop;
    t_item     push_item;
    t_item     pop_item;

    ats_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_user     (s_axis_tuser),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    ats_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    ats_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (pop_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

// ----- sim/affine_transform_save_stack_test.sv -----
// Self-checking test of affine_transform_save_stack: directed table, then random command streams.
// Results are predicted in the bench and compared field by field on every output transfer.
// Depends on src/ats_pkg.sv and src/affine_transform_save_stack.sv.
`timescale 1ns / 100ps

module affine_transform_save_stack_test;
    import ats_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;
    localparam int DRAIN_EVERY    = 500;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    localparam t_coef COEF_MAX = 32'sh7FFFFFFF;
    localparam t_coef COEF_MIN = 32'sh80000000;
    localparam longint SAT_HI  = 64'sd2147483647;
    localparam longint SAT_LO  = -64'sd2147483648;

    typedef struct packed {
        t_mat                   m;
        logic                   lost;
        logic [LEVEL_OUT_W-1:0] level;
    } t_ctm_result;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        t_mat             m;
        logic [CNT_W-1:0] cnt;
        logic             lost;
        logic             typed;
        t_ctm_result      want;
    } t_ctm_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    affine_transform_save_stack dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the transform state
    longint ctm_now[N_COEF];
    longint saved_ctm[STACK_DEPTH][N_COEF];
    int     level_now;
    logic   lost_now;

    t_ctm_result pending_ctm[$];
    t_ctm_row    table_rows[$];

    int errors = 0;
    int results_checked = 0;
    int cmd_seen[8];
    int deepest_level = 0;
    int full_stack_saves = 0;
    int saturated_coefs = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    logic [9:0] ready_phase = '0;

    function automatic t_mat mat6(t_coef a, t_coef b, t_coef c, t_coef d, t_coef e, t_coef f);
        t_mat r;
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        r.e = e;
        r.f = f;
        return r;
    endfunction

    // (p + q) scaled down by FRAC_BITS, nearest with ties upward, plus t, saturated
    function automatic longint round_sat(longint p, longint q, longint t);
        longint mask;
        longint lo;
        longint total;
        mask  = (64'sd1 <<< FRAC_BITS) - 1;
        lo    = (p & mask) + (q & mask) + (64'sd1 <<< (FRAC_BITS - 1));
        total = (p >>> FRAC_BITS) + (q >>> FRAC_BITS) + (lo >>> FRAC_BITS) + t;
        if (total > SAT_HI) begin
            return SAT_HI;
        end
        if (total < SAT_LO) begin
            return SAT_LO;
        end
        return total;
    endfunction

    // unused command codes for the random stream
    function automatic logic [CMD_W-1:0] spare_cmd(int pick);
        case (pick % 3)
            0: return CMD_SPARE_LO;
            1: return CMD_SPARE_MID;
            default: return CMD_SPARE_HI;
        endcase
    endfunction

    task automatic reset_ctm();
        int k;
        for (k = 0; k < N_COEF; k++) begin
            ctm_now[k] = 0;
        end
        ctm_now[0] = longint'(COEF_ONE);
        ctm_now[3] = longint'(COEF_ONE);
        level_now  = 0;
        lost_now   = 1'b0;
    endtask

    task automatic apply_ctm_command(input logic [CMD_W-1:0] op, input t_mat m,
                                     input logic [CNT_W-1:0] cnt, input logic lost_in,
                                     output t_ctm_result res);
        longint mv[N_COEF];
        longint nxt[N_COEF];
        int k;
        int present;
        for (k = 0; k < N_COEF; k++) begin
            mv[k] = longint'($signed(m[k*COEF_W +: COEF_W]));
        end
        case (op)
            CMD_BEGIN: begin
                ctm_now   = mv;
                lost_now  = lost_in;
                level_now = 0;
            end
            CMD_SAVE: begin
                if (!lost_now) begin
                    if (level_now >= STACK_DEPTH) begin
                        lost_now = 1'b1;
                        full_stack_saves++;
                    end else begin
                        saved_ctm[level_now] = ctm_now;
                        level_now++;
                    end
                end
            end
            CMD_RESTORE: begin
                if (!lost_now && level_now > 0) begin
                    level_now--;
                    ctm_now = saved_ctm[level_now];
                end
            end
            CMD_CONCAT: begin
                present = (cnt > N_COEF) ? N_COEF : int'(cnt);
                for (k = 0; k < N_COEF - present; k++) begin
                    mv[k] = 0;
                end
                nxt[0] = round_sat(mv[0] * ctm_now[0], mv[1] * ctm_now[2], 0);
                nxt[1] = round_sat(mv[0] * ctm_now[1], mv[1] * ctm_now[3], 0);
                nxt[2] = round_sat(mv[2] * ctm_now[0], mv[3] * ctm_now[2], 0);
                nxt[3] = round_sat(mv[2] * ctm_now[1], mv[3] * ctm_now[3], 0);
                nxt[4] = round_sat(mv[4] * ctm_now[0], mv[5] * ctm_now[2], ctm_now[4]);
                nxt[5] = round_sat(mv[4] * ctm_now[1], mv[5] * ctm_now[3], ctm_now[5]);
                ctm_now = nxt;
                for (k = 0; k < N_COEF; k++) begin
                    if (ctm_now[k] == SAT_HI || ctm_now[k] == SAT_LO) begin
                        saturated_coefs++;
                    end
                end
            end
            default: begin
            end
        endcase
        if (level_now > deepest_level) begin
            deepest_level = level_now;
        end
        for (k = 0; k < N_COEF; k++) begin
            res.m[k*COEF_W +: COEF_W] = 32'(ctm_now[k]);
        end
        res.lost  = lost_now;
        res.level = LEVEL_OUT_W'(level_now);
    endtask

    // one input transfer; the gap, if any, comes before the item is offered
    task automatic send_item(input logic [CMD_W-1:0] op, input t_mat m,
                             input logic [CNT_W-1:0] cnt, input logic lost_in,
                             input logic typed, input t_ctm_result want);
        int gap;
        t_ctm_result res;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3);
            burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= S_TDATA_W'({lost_in, cnt, m});
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        cmd_seen[op]++;
        apply_ctm_command(op, m, cnt, lost_in, res);
        pending_ctm.push_back(typed ? want : res);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_ctm.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [CMD_W-1:0] op, input t_mat m,
                           input logic [CNT_W-1:0] cnt, input logic lost_in,
                           input logic typed, input t_mat want_m,
                           input logic want_lost, input int want_level);
        t_ctm_row row;
        row.op         = op;
        row.m          = m;
        row.cnt        = cnt;
        row.lost       = lost_in;
        row.typed      = typed;
        row.want.m     = want_m;
        row.want.lost  = want_lost;
        row.want.level = LEVEL_OUT_W'(want_level);
        table_rows.push_back(row);
    endtask

    function automatic t_coef rand_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return t_coef'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            5: return ($urandom_range(0, 1) == 1) ? COEF_ONE : -COEF_ONE;
            6: return '0;
            7: begin
                case ($urandom_range(0, 3))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            default: return t_coef'($urandom());
        endcase
    endfunction

    function automatic t_mat rand_mat();
        return mat6(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    endfunction

    // receiver: ready pattern changes with bits [9:8] of a free-running phase counter
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 10'd1;
        case (ready_phase[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (ready_phase[2:0] != 3'd0);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_ctm_result want;
        int k;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_ctm.size() == 0) begin
                $display("%0t ns: result with nothing pending, got %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_ctm.pop_front();
                results_checked++;
                for (k = 0; k < N_COEF; k++) begin
                    if (want.m[k*COEF_W +: COEF_W] !== m_axis_tdata[k*COEF_W +: COEF_W]) begin
                        $display("%0t ns: out_%c expected %h, got %h", $time, 8'h61 + k,
                                 want.m[k*COEF_W +: COEF_W], m_axis_tdata[k*COEF_W +: COEF_W]);
                        errors++;
                    end
                end
                if (want.lost !== m_axis_tdata[N_COEF*COEF_W]) begin
                    $display("%0t ns: lost_flag expected %b, got %b", $time, want.lost,
                             m_axis_tdata[N_COEF*COEF_W]);
                    errors++;
                end
                if (want.level !== m_axis_tdata[N_COEF*COEF_W+1 +: LEVEL_OUT_W]) begin
                    $display("%0t ns: stack_level expected %0d, got %0d", $time, want.level,
                             m_axis_tdata[N_COEF*COEF_W+1 +: LEVEL_OUT_W]);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding", $time,
                     idle_cycles, pending_ctm.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_mat ident, all_max, all_min, start_m, tiny_m, zero_m;
        t_ctm_row row;
        t_ctm_result none;
        logic [CMD_W-1:0] op;
        logic [CNT_W-1:0] cnt;
        logic lost_in;
        int save_run, pop_run, sent, drain_at, pick, k;

        ident   = mat6(COEF_ONE, '0, '0, COEF_ONE, '0, '0);
        all_max = mat6(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        all_min = mat6(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        start_m = mat6(32'sh00018000, -32'sh00004000, 32'sh00002000, -32'sh00010000,
                       32'sh12345678, -32'sh00ABCDEF);
        tiny_m  = mat6(32'sd1, '0, '0, 32'sd1, '0, '0);
        zero_m  = '0;
        none    = '0;
        for (k = 0; k < 8; k++) begin
            cmd_seen[k] = 0;
        end
        reset_ctm();

        add_row(CMD_QUERY,    all_max, 3'd6, 1'b1, 1'b1, ident, 1'b0, 0);
        add_row(CMD_SPARE_LO, all_min, 3'd6, 1'b0, 1'b1, ident, 1'b0, 0);
        add_row(CMD_SPARE_HI, all_max, 3'd7, 1'b1, 1'b1, ident, 1'b0, 0);
        add_row(CMD_RESTORE,  all_max, 3'd6, 1'b0, 1'b1, ident, 1'b0, 0);
        add_row(CMD_SAVE,     all_min, 3'd0, 1'b0, 1'b1, ident, 1'b0, 1);
        add_row(CMD_BEGIN,    all_max, 3'd6, 1'b0, 1'b1, all_max, 1'b0, 0);
        add_row(CMD_CONCAT,   all_max, 3'd6, 1'b0, 1'b1, all_max, 1'b0, 0);
        add_row(CMD_BEGIN,    all_min, 3'd7, 1'b0, 1'b1, all_min, 1'b0, 0);
        add_row(CMD_CONCAT,   all_max, 3'd7, 1'b0, 1'b1, all_min, 1'b0, 0);
        add_row(CMD_BEGIN,    ident,   3'd0, 1'b1, 1'b1, ident, 1'b1, 0);
        add_row(CMD_SAVE,     all_max, 3'd6, 1'b0, 1'b1, ident, 1'b1, 0);
        add_row(CMD_RESTORE,  all_min, 3'd6, 1'b0, 1'b1, ident, 1'b1, 0);
        add_row(CMD_BEGIN,    start_m, 3'd0, 1'b0, 1'b1, start_m, 1'b0, 0);
        add_row(CMD_SAVE,     zero_m,  3'd6, 1'b0, 1'b1, start_m, 1'b0, 1);
        add_row(CMD_CONCAT,   all_max, 3'd0, 1'b0, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_CONCAT, mat6(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_ONE, COEF_ONE),
                3'd2, 1'b0, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_CONCAT, mat6(COEF_MAX, COEF_MIN, 32'sh00008000, 32'sh00030000,
                -32'sh00018000, 32'sh7FFF0000), 3'd4, 1'b0, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_RESTORE,  all_max, 3'd6, 1'b0, 1'b1, start_m, 1'b0, 0);
        add_row(CMD_BEGIN,    tiny_m,  3'd6, 1'b0, 1'b1, tiny_m, 1'b0, 0);
        // rounding ties, one on each side of zero
        add_row(CMD_CONCAT, mat6(32'sh8000, '0, '0, -32'sh8000, 32'sh8000, -32'sh8000),
                3'd6, 1'b0, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_CONCAT, mat6(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN),
                3'd1, 1'b0, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_QUERY,     start_m, 3'd3, 1'b1, 1'b0, zero_m, 1'b0, 0);
        add_row(CMD_SPARE_MID, start_m, 3'd5, 1'b0, 1'b0, zero_m, 1'b0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[n]) begin
            row = table_rows[n];
            send_item(row.op, row.m, row.cnt, row.lost, row.typed, row.want);
        end
        wait_all_results();

        save_run = 0;
        pop_run  = 0;
        sent     = 0;
        drain_at = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS) begin
            cnt     = CNT_W'($urandom_range(0, 7));
            lost_in = ($urandom_range(0, 7) == 0);
            pick    = $urandom_range(0, 99);
            if (save_run > 0) begin
                op = CMD_SAVE;
                save_run--;
            end else if (pop_run > 0) begin
                op = CMD_RESTORE;
                pop_run--;
            end else if (lost_now && pick < 40) begin
                op = CMD_BEGIN;
                lost_in = 1'b0;
            end else if (pick < 2) begin
                op = CMD_SAVE;
                save_run = $urandom_range(20, 40);
            end else if (pick < 4) begin
                op = CMD_RESTORE;
                pop_run = $urandom_range(5, 35);
            end else if (pick < 10) begin
                op = CMD_BEGIN;
            end else if (pick < 35) begin
                op = CMD_SAVE;
            end else if (pick < 58) begin
                op = CMD_RESTORE;
            end else if (pick < 88) begin
                op = CMD_CONCAT;
                if ($urandom_range(0, 2) != 0) begin
                    cnt = CNT_W'(N_COEF);
                end
            end else if (pick < 95) begin
                op = CMD_QUERY;
            end else begin
                op = spare_cmd(pick);
            end
            send_item(op, rand_mat(), cnt, lost_in, 1'b0, none);
            sent++;
            if (sent >= drain_at) begin
                wait_all_results();
                drain_at += DRAIN_EVERY;
            end
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d begin, %0d save, %0d restore, %0d concat, %0d query, %0d checked",
                 cmd_seen[CMD_BEGIN], cmd_seen[CMD_SAVE], cmd_seen[CMD_RESTORE],
                 cmd_seen[CMD_CONCAT],
                 cmd_seen[CMD_QUERY] + cmd_seen[CMD_SPARE_LO] + cmd_seen[CMD_SPARE_MID]
                 + cmd_seen[CMD_SPARE_HI], results_checked);
        $display("Deepest stack %0d, %0d saves into a full stack, %0d saturated coefficients",
                 deepest_level, full_stack_saves, saturated_coefs);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ats_pkg.sv
src/ats_front.sv
src/ats_queue.sv
src/ats_back.sv
src/affine_transform_save_stack.sv
sim/affine_transform_save_stack_test.sv
